// ===== rtl/rmq_pkg.sv =====
// Shared types, constants and arithmetic step functions of the matrix-to-quaternion unit.
package rmq_pkg;

    localparam int WORD_WIDTH = 16;
    localparam int FRAC_BITS  = WORD_WIDTH - 2;

    localparam int V_W    = WORD_WIDTH + 2;      // diagonal sums 4c^2-1
    localparam int T_W    = WORD_WIDTH + 1;      // largest value plus one
    localparam int X_W    = 2 * WORD_WIDTH;      // radicand
    localparam int ROOT_W = WORD_WIDTH;
    localparam int SQR_W  = WORD_WIDTH + 2;      // root remainder
    localparam int S_W    = WORD_WIDTH + 1;      // off-diagonal sums, signed
    localparam int MAG_W  = WORD_WIDTH + 1;
    localparam int NUM_W  = 2 * WORD_WIDTH - 2;  // rounded dividend
    localparam int DEN_W  = WORD_WIDTH;
    localparam int DVR_W  = WORD_WIDTH + 1;      // divider remainder
    localparam int Q_W    = WORD_WIDTH;

    localparam logic [1:0] COMP_W = 2'd0;
    localparam logic [1:0] COMP_X = 2'd1;
    localparam logic [1:0] COMP_Y = 2'd2;
    localparam logic [1:0] COMP_Z = 2'd3;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] rot_00;
        logic signed [WORD_WIDTH-1:0] rot_01;
        logic signed [WORD_WIDTH-1:0] rot_02;
        logic signed [WORD_WIDTH-1:0] rot_10;
        logic signed [WORD_WIDTH-1:0] rot_11;
        logic signed [WORD_WIDTH-1:0] rot_12;
        logic signed [WORD_WIDTH-1:0] rot_20;
        logic signed [WORD_WIDTH-1:0] rot_21;
        logic signed [WORD_WIDTH-1:0] rot_22;
    } t_mat;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] quat_w;
        logic signed [WORD_WIDTH-1:0] quat_x;
        logic signed [WORD_WIDTH-1:0] quat_y;
        logic signed [WORD_WIDTH-1:0] quat_z;
        logic [1:0]                   largest_component;
    } t_quat;

    typedef struct packed {
        logic [SQR_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq_state;

    typedef struct packed {
        logic [DVR_W-1:0] rem;
        logic [Q_W-1:0]   quo;
    } t_dv_state;

    // One root bit: bring down two radicand bits, try subtracting 4*root+1 (that is {root, 2'b01}).
    function automatic t_sq_state sqrt_step(t_sq_state cur, logic [1:0] pair);
        logic [SQR_W-1:0] acc;
        logic [SQR_W-1:0] trial;
        t_sq_state        nxt;
        acc   = {cur.rem[SQR_W-3:0], pair};
        trial = {cur.root, 2'b01};
        if (acc >= trial) begin
            nxt.rem  = acc - trial;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            nxt.rem  = acc;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    // One quotient bit of restoring division.
    function automatic t_dv_state div_step(t_dv_state cur, logic [DEN_W-1:0] den, logic nbit);
        logic [DVR_W-1:0] acc;
        t_dv_state        nxt;
        acc = {cur.rem[DVR_W-2:0], nbit};
        if (acc >= {1'b0, den}) begin
            nxt.rem = acc - {1'b0, den};
            nxt.quo = {cur.quo[Q_W-2:0], 1'b1};
        end else begin
            nxt.rem = acc;
            nxt.quo = {cur.quo[Q_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    // Apply sign to a magnitude and clamp to the output word.
    function automatic logic signed [WORD_WIDTH-1:0] pack_signed(logic neg, logic [Q_W-1:0] mag);
        logic [Q_W-1:0] lim;
        logic [Q_W-1:0] m;
        logic [Q_W-1:0] res;
        if (!neg) begin
            lim = {1'b0, {(Q_W-1){1'b1}}};
            m   = (mag > lim) ? lim : mag;
            res = m;
        end else begin
            lim = {1'b1, {(Q_W-1){1'b0}}};
            m   = (mag > lim) ? lim : mag;
            res = ~m + 1'b1;
        end
        return signed'(res);
    endfunction

endpackage

// ===== rtl/rotation_matrix_to_quaternion_unit.sv =====
// Top level: fully pipelined rotation matrix to unit quaternion converter.
//
// Usage: drive a 3x3 rotation matrix (signed Q2.14 entries) on i_mat and raise start; the
// beat is taken at any rising edge where start is high and busy is low. busy is high only
// while reset is applied and until the first edge that sees it released, so the unit takes
// one matrix every cycle. Each result beat appears on o_quat for exactly one cycle with
// o_strobe high, in the order the matrices came in. The receiver cannot hold results off,
// so sample o_quat whenever o_strobe is high. The pipeline holds the square root, which
// yields one root bit per stage over WORD_WIDTH stages, followed by three restoring
// dividers that each yield one quotient bit per stage over another WORD_WIDTH stages; the
// remaining four stages form the diagonal sums, pick the largest component, halve the root
// and saturate the outputs. The largest component is returned on largest_component (0 w,
// 1 x, 2 y, 3 z); ties go to the earlier component. The other three components are rounded
// to nearest, ties away from zero, and every component is clamped to the Q2.14 range. Any
// bit pattern is accepted.
module rotation_matrix_to_quaternion_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  rmq_pkg::t_mat  i_mat,
    output logic           o_strobe,
    output rmq_pkg::t_quat o_quat
);
    import rmq_pkg::*;

    localparam int W       = WORD_WIDTH;
    localparam int NLANE   = 3;
    localparam int LATENCY = 2 * W + 4;

    localparam logic [T_W-1:0]          Q_ONE_T = T_W'(1) << FRAC_BITS;
    localparam logic signed [W-1:0]     HALF_Q  = W'(1) << (FRAC_BITS - 1);

    logic accept;
    logic r_busy;

    assign accept = start && !busy;
    assign busy   = r_busy;

    // ---------------------------------------------------------------------------------
    // Stage 1: diagonal sums and every off-diagonal sum or difference that may be needed
    // ---------------------------------------------------------------------------------
    logic                    r_s1_vld;
    logic signed [V_W-1:0]   r_v   [4];
    logic signed [V_W-1:0]   n_v   [4];
    logic signed [S_W-1:0]   r_c_zy, r_c_xz, r_c_yx, r_c_pxy, r_c_pxz, r_c_pyz;
    logic signed [S_W-1:0]   n_c_zy, n_c_xz, n_c_yx, n_c_pxy, n_c_pxz, n_c_pyz;

    always_comb begin
        logic signed [V_W-1:0] e00, e11, e22;
        e00 = V_W'(i_mat.rot_00);
        e11 = V_W'(i_mat.rot_11);
        e22 = V_W'(i_mat.rot_22);
        n_v[0] = e00 + e11 + e22;
        n_v[1] = e00 - e11 - e22;
        n_v[2] = e11 - e00 - e22;
        n_v[3] = e22 - e00 - e11;
        n_c_zy  = S_W'(i_mat.rot_21) - S_W'(i_mat.rot_12);
        n_c_xz  = S_W'(i_mat.rot_02) - S_W'(i_mat.rot_20);
        n_c_yx  = S_W'(i_mat.rot_10) - S_W'(i_mat.rot_01);
        n_c_pxy = S_W'(i_mat.rot_01) + S_W'(i_mat.rot_10);
        n_c_pxz = S_W'(i_mat.rot_02) + S_W'(i_mat.rot_20);
        n_c_pyz = S_W'(i_mat.rot_21) + S_W'(i_mat.rot_12);
    end

    // ---------------------------------------------------------------------------------
    // Stage 2: pick the largest value, form the radicand, route three terms to the lanes
    // ---------------------------------------------------------------------------------
    logic [1:0]              n_idx;
    logic [X_W-1:0]          n_x;
    logic [NLANE-1:0]        n_neg;
    logic [MAG_W-1:0]        n_mag [NLANE];

    always_comb begin
        logic                  a01, b23;
        logic signed [V_W-1:0] va, vb, vmax;
        logic [1:0]            ia, ib;
        logic [T_W-1:0]        t;
        logic signed [S_W-1:0] sel [NLANE];
        // pairwise first; a later entry wins only when strictly greater
        a01 = r_v[1] > r_v[0];
        va  = a01 ? r_v[1] : r_v[0];
        ia  = a01 ? COMP_X : COMP_W;
        b23 = r_v[3] > r_v[2];
        vb  = b23 ? r_v[3] : r_v[2];
        ib  = b23 ? COMP_Z : COMP_Y;
        if (vb > va) begin
            vmax  = vb;
            n_idx = ib;
        end else begin
            vmax  = va;
            n_idx = ia;
        end
        // largest value is never negative, so the low bits hold it exactly
        t   = vmax[T_W-1:0] + Q_ONE_T;
        n_x = {1'b0, t, {FRAC_BITS{1'b0}}};
        case (n_idx)
            COMP_W: begin
                sel[0] = r_c_zy;  sel[1] = r_c_xz;  sel[2] = r_c_yx;
            end
            COMP_X: begin
                sel[0] = r_c_zy;  sel[1] = r_c_pxy; sel[2] = r_c_pxz;
            end
            COMP_Y: begin
                sel[0] = r_c_xz;  sel[1] = r_c_pxy; sel[2] = r_c_pyz;
            end
            COMP_Z: begin
                sel[0] = r_c_yx;  sel[1] = r_c_pxz; sel[2] = r_c_pyz;
            end
            default: begin
                sel[0] = r_c_zy;  sel[1] = r_c_xz;  sel[2] = r_c_yx;
            end
        endcase
        for (int j = 0; j < NLANE; j++) begin
            n_neg[j] = sel[j][S_W-1];
            n_mag[j] = n_neg[j] ? MAG_W'(-sel[j]) : MAG_W'(sel[j]);
        end
    end

    // ---------------------------------------------------------------------------------
    // Square root pipeline: entry 0 is loaded from stage 2, entry k+1 holds k+1 root bits
    // ---------------------------------------------------------------------------------
    logic [W:0]              r_sq_vld;
    t_sq_state               r_sq     [W+1];
    t_sq_state               n_sq     [W];
    logic [X_W-1:0]          r_sq_x   [W+1];
    logic [1:0]              r_sq_idx [W+1];
    logic [NLANE-1:0]        r_sq_neg [W+1];
    logic [MAG_W-1:0]        r_sq_mag [W+1][NLANE];

    always_comb begin
        for (int k = 0; k < W; k++) begin
            n_sq[k] = sqrt_step(r_sq[k], r_sq_x[k][2*(W-1-k) +: 2]);
        end
    end

    // ---------------------------------------------------------------------------------
    // Rounding stage: halve the root, build divisor and rounded dividends per lane
    // ---------------------------------------------------------------------------------
    logic [DEN_W-1:0]        n_big;
    logic [DEN_W-1:0]        n_den;
    logic [NUM_W-1:0]        n_num [NLANE];

    always_comb begin
        logic [ROOT_W:0] rp1;
        rp1   = {1'b0, r_sq[W].root} + 1'b1;
        n_big = rp1[ROOT_W:1];
        n_den = {n_big[DEN_W-2:0], 1'b0};
        // round(mag*2^F / (4*big)) = floor((mag*2^(F-1) + big) / (2*big))
        for (int j = 0; j < NLANE; j++) begin
            n_num[j] = (NUM_W'(r_sq_mag[W][j]) << (FRAC_BITS - 1)) + NUM_W'(n_big);
        end
    end

    // ---------------------------------------------------------------------------------
    // Divider pipeline: three lanes, one quotient bit per stage
    // ---------------------------------------------------------------------------------
    logic [W:0]              r_dv_vld;
    t_dv_state               r_dv     [W+1][NLANE];
    t_dv_state               n_dv     [W][NLANE];
    logic [NUM_W-1:0]        r_dv_num [W+1][NLANE];
    logic [DEN_W-1:0]        r_dv_den [W+1];
    logic [DEN_W-1:0]        r_dv_big [W+1];
    logic [1:0]              r_dv_idx [W+1];
    logic [NLANE-1:0]        r_dv_neg [W+1];

    always_comb begin
        for (int k = 0; k < W; k++) begin
            for (int j = 0; j < NLANE; j++) begin
                n_dv[k][j] = div_step(r_dv[k][j], r_dv_den[k], r_dv_num[k][j][W-1-k]);
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Output stage: saturate, place the largest component, register the result beat
    // ---------------------------------------------------------------------------------
    logic                    r_out_vld;
    t_quat                   r_out;
    t_quat                   n_out;

    always_comb begin
        logic signed [W-1:0] lane [NLANE];
        logic signed [W-1:0] big;
        for (int j = 0; j < NLANE; j++) begin
            lane[j] = pack_signed(r_dv_neg[W][j], r_dv[W][j].quo);
        end
        // the halved root stays below 2^(W-1.5), so it always fits the signed word
        big = signed'(r_dv_big[W]);
        n_out.largest_component = r_dv_idx[W];
        case (r_dv_idx[W])
            COMP_W: begin
                n_out.quat_w = big;     n_out.quat_x = lane[0];
                n_out.quat_y = lane[1]; n_out.quat_z = lane[2];
            end
            COMP_X: begin
                n_out.quat_w = lane[0]; n_out.quat_x = big;
                n_out.quat_y = lane[1]; n_out.quat_z = lane[2];
            end
            COMP_Y: begin
                n_out.quat_w = lane[0]; n_out.quat_x = lane[1];
                n_out.quat_y = big;     n_out.quat_z = lane[2];
            end
            COMP_Z: begin
                n_out.quat_w = lane[0]; n_out.quat_x = lane[1];
                n_out.quat_y = lane[2]; n_out.quat_z = big;
            end
            default: begin
                n_out.quat_w = big;     n_out.quat_x = lane[0];
                n_out.quat_y = lane[1]; n_out.quat_z = lane[2];
            end
        endcase
    end

    assign o_strobe = r_out_vld;
    assign o_quat   = r_out;

    // ---------------------------------------------------------------------------------
    // Control: valid bits advance every cycle; nothing ever stalls
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_s1_vld  <= 1'b0;
            r_sq_vld  <= '0;
            r_dv_vld  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_busy    <= 1'b0;
            r_s1_vld  <= accept;
            r_sq_vld  <= {r_sq_vld[W-1:0], r_s1_vld};
            r_dv_vld  <= {r_dv_vld[W-1:0], r_sq_vld[W]};
            r_out_vld <= r_dv_vld[W];
        end
    end

    // Payload: capture every cycle, the valid bits tell which beats are real
    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_c_zy  <= n_c_zy;
        r_c_xz  <= n_c_xz;
        r_c_yx  <= n_c_yx;
        r_c_pxy <= n_c_pxy;
        r_c_pxz <= n_c_pxz;
        r_c_pyz <= n_c_pyz;

        r_sq[0]     <= '0;
        r_sq_x[0]   <= n_x;
        r_sq_idx[0] <= n_idx;
        r_sq_neg[0] <= n_neg;
        r_sq_mag[0] <= n_mag;
        for (int k = 0; k < W; k++) begin
            r_sq[k+1]     <= n_sq[k];
            r_sq_x[k+1]   <= r_sq_x[k];
            r_sq_idx[k+1] <= r_sq_idx[k];
            r_sq_neg[k+1] <= r_sq_neg[k];
            r_sq_mag[k+1] <= r_sq_mag[k];
        end

        r_dv_den[0] <= n_den;
        r_dv_big[0] <= n_big;
        r_dv_idx[0] <= r_sq_idx[W];
        r_dv_neg[0] <= r_sq_neg[W];
        for (int j = 0; j < NLANE; j++) begin
            // top dividend bits are already below the divisor
            r_dv[0][j].rem <= {3'b000, n_num[j][NUM_W-1:W]};
            r_dv[0][j].quo <= '0;
            r_dv_num[0][j] <= n_num[j];
        end
        for (int k = 0; k < W; k++) begin
            r_dv[k+1]     <= n_dv[k];
            r_dv_num[k+1] <= r_dv_num[k];
            r_dv_den[k+1] <= r_dv_den[k];
            r_dv_big[k+1] <= r_dv_big[k];
            r_dv_idx[k+1] <= r_dv_idx[k];
            r_dv_neg[k+1] <= r_dv_neg[k];
        end

        r_out <= n_out;
    end

    // ---------------------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_strobe)
        else $error("result beat missing at fixed latency");

    a_root_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_vld[W] |-> (r_sq[W].rem <= SQR_W'({r_sq[W].root, 1'b0})))
        else $error("square root remainder out of bounds");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[W] |-> ((r_dv[W][0].rem < {1'b0, r_dv_den[W]}) &&
                         (r_dv[W][1].rem < {1'b0, r_dv_den[W]}) &&
                         (r_dv[W][2].rem < {1'b0, r_dv_den[W]})))
        else $error("divider remainder not below divisor");

    a_largest_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |->
            ((o_quat.largest_component != COMP_W || o_quat.quat_w >= HALF_Q) &&
             (o_quat.largest_component != COMP_X || o_quat.quat_x >= HALF_Q) &&
             (o_quat.largest_component != COMP_Y || o_quat.quat_y >= HALF_Q) &&
             (o_quat.largest_component != COMP_Z || o_quat.quat_z >= HALF_Q)))
        else $error("largest component below one half");

endmodule

// ===== test/rmq_checker.sv =====
// Checker for the matrix-to-quaternion unit: predicts each quaternion and compares beats.
`timescale 1ns / 100ps

module rmq_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  rmq_pkg::t_mat     i_mat,
    input  logic              i_strobe,
    input  rmq_pkg::t_quat    i_quat,
    output int                o_fails,
    output int                o_pending,
    output int                o_checked,
    output logic [3:0][31:0]  o_hits
);
    import rmq_pkg::*;

    localparam longint Q_ONE    = longint'(1) << FRAC_BITS;
    localparam longint POS_LIM  = (longint'(1) << (WORD_WIDTH - 1)) - 1;
    localparam longint NEG_LIM  = longint'(1) << (WORD_WIDTH - 1);

    t_quat quat_due[$];
    t_quat want;
    int    fails   = 0;
    int    checked = 0;
    int    pending = 0;
    int    hits[4] = '{0, 0, 0, 0};

    assign o_fails   = fails;
    assign o_pending = pending;
    assign o_checked = checked;
    assign o_hits    = {hits[3], hits[2], hits[1], hits[0]};

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        int              b;
        r = 0;
        for (b = 31; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic logic signed [WORD_WIDTH-1:0] clamp_word(logic neg, longint mag);
        if (!neg)
            return WORD_WIDTH'((mag > POS_LIM) ? POS_LIM : mag);
        return WORD_WIDTH'((mag > NEG_LIM) ? -NEG_LIM : -mag);
    endfunction

    // Off-diagonal sum scaled by 1/(4*big), rounded half away from zero.
    function automatic logic signed [WORD_WIDTH-1:0] share_of(longint s, longint big);
        logic   neg;
        longint mag;
        neg = (s < 0);
        mag = neg ? -s : s;
        return clamp_word(neg, (2 * (mag << FRAC_BITS) + 4 * big) / (8 * big));
    endfunction

    function automatic t_quat quat_of_matrix(t_mat m);
        longint     e00, e01, e02, e10, e11, e12, e20, e21, e22;
        longint     diag[4];
        longint     s[4];
        longint     big;
        logic [1:0] lead;
        t_quat      q;
        logic signed [WORD_WIDTH-1:0] c[4];
        int         k;
        e00 = m.rot_00; e01 = m.rot_01; e02 = m.rot_02;
        e10 = m.rot_10; e11 = m.rot_11; e12 = m.rot_12;
        e20 = m.rot_20; e21 = m.rot_21; e22 = m.rot_22;
        diag[0] = e00 + e11 + e22;
        diag[1] = e00 - e11 - e22;
        diag[2] = e11 - e00 - e22;
        diag[3] = e22 - e00 - e11;
        lead = COMP_W;
        for (k = 1; k < 4; k++)
            if (diag[k] > diag[lead])
                lead = k[1:0];
        big = (root_floor(longint'(unsigned'(diag[lead] + Q_ONE)) << FRAC_BITS) + 1) >> 1;
        s = '{0, 0, 0, 0};
        case (lead)
            COMP_W: begin
                s[1] = e21 - e12; s[2] = e02 - e20; s[3] = e10 - e01;
            end
            COMP_X: begin
                s[0] = e21 - e12; s[2] = e01 + e10; s[3] = e02 + e20;
            end
            COMP_Y: begin
                s[0] = e02 - e20; s[1] = e01 + e10; s[3] = e21 + e12;
            end
            default: begin
                s[0] = e10 - e01; s[1] = e02 + e20; s[2] = e21 + e12;
            end
        endcase
        for (k = 0; k < 4; k++)
            c[k] = (k == lead) ? clamp_word(1'b0, big) : share_of(s[k], big);
        q.quat_w            = c[0];
        q.quat_x            = c[1];
        q.quat_y            = c[2];
        q.quat_z            = c[3];
        q.largest_component = lead;
        return q;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fails++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] got_v);
        if (got_v !== exp_v)
            report_mismatch($sformatf("%s expected %0d, got %0d", name, exp_v, got_v));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !i_busy)
            quat_due.push_back(quat_of_matrix(i_mat));
        if (i_rst_n && i_strobe !== 1'b0) begin
            if (i_strobe !== 1'b1) begin
                report_mismatch("strobe unknown");
            end else if (quat_due.size() == 0) begin
                report_mismatch("result beat with no matrix waiting");
            end else begin
                want = quat_due.pop_front();
                check_field("quat_w", want.quat_w, i_quat.quat_w);
                check_field("quat_x", want.quat_x, i_quat.quat_x);
                check_field("quat_y", want.quat_y, i_quat.quat_y);
                check_field("quat_z", want.quat_z, i_quat.quat_z);
                check_field("largest_component", want.largest_component,
                            i_quat.largest_component);
                checked++;
                hits[want.largest_component]++;
            end
        end
        pending = quat_due.size();
    end

endmodule

// ===== test/testbench.sv =====
// Top of the matrix-to-quaternion testbench: clock, reset, matrix stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import rmq_pkg::*;

    localparam int  Q1         = 1 << FRAC_BITS;   // 1.0 in Q2.14
    localparam int  RAND_BEATS = 700;
    localparam int  DRAIN_WAIT = 2 * WORD_WIDTH + 8; // pipeline depth plus margin

    logic             clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_mat             i_mat;
    logic             o_strobe;
    t_quat            o_quat;
    int               fails;
    int               pending;
    int               checked;
    logic [3:0][31:0] hits;

    int   sent;
    int   directed;
    logic calm;     // high while the sender must not idle

    rotation_matrix_to_quaternion_unit dut (
        .i_clk    (clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_mat    (i_mat),
        .o_strobe (o_strobe),
        .o_quat   (o_quat)
    );

    rmq_checker quat_watch (
        .i_clk     (clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_mat     (i_mat),
        .i_strobe  (o_strobe),
        .i_quat    (o_quat),
        .o_fails   (fails),
        .o_pending (pending),
        .o_checked (checked),
        .o_hits    (hits)
    );

    // 4 ns period
    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Build a matrix from nine integers, row by row; wrap to the word width.
    function automatic t_mat mat_of(int a00, int a01, int a02, int a10, int a11, int a12,
                                    int a20, int a21, int a22);
        t_mat m;
        m.rot_00 = WORD_WIDTH'(a00); m.rot_01 = WORD_WIDTH'(a01); m.rot_02 = WORD_WIDTH'(a02);
        m.rot_10 = WORD_WIDTH'(a10); m.rot_11 = WORD_WIDTH'(a11); m.rot_12 = WORD_WIDTH'(a12);
        m.rot_20 = WORD_WIDTH'(a20); m.rot_21 = WORD_WIDTH'(a21); m.rot_22 = WORD_WIDTH'(a22);
        return m;
    endfunction

    // Convert a real entry to Q2.14, add a little jitter, and clamp to the word.
    function automatic int to_fixed(real r, int jitter);
        int v;
        v = $rtoi(r * Q1 + ((r < 0.0) ? -0.5 : 0.5));
        if (jitter > 0)
            v = v + int'($urandom_range(0, 2 * jitter)) - jitter;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    // Proper rotation matrix from a quaternion (normalised here).
    function automatic t_mat rot_of_quat(real a, real b, real c, real d, int jitter);
        real n;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 0.001) begin
            a = 1.0; b = 0.0; c = 0.0; d = 0.0; n = 1.0;
        end
        a = a / n; b = b / n; c = c / n; d = d / n;
        return mat_of(
            to_fixed(1.0 - 2.0 * (c * c + d * d), jitter),
            to_fixed(2.0 * (b * c - a * d), jitter),
            to_fixed(2.0 * (b * d + a * c), jitter),
            to_fixed(2.0 * (b * c + a * d), jitter),
            to_fixed(1.0 - 2.0 * (b * b + d * d), jitter),
            to_fixed(2.0 * (c * d - a * b), jitter),
            to_fixed(2.0 * (b * d - a * c), jitter),
            to_fixed(2.0 * (c * d + a * b), jitter),
            to_fixed(1.0 - 2.0 * (b * b + c * c), jitter));
    endfunction

    function automatic real unit_rand();
        return (real'(int'($urandom_range(0, 2000))) - 1000.0) / 1000.0;
    endfunction

    // Word biased toward the corners of the range.
    function automatic int corner_word();
        case ($urandom_range(0, 5))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return Q1;
            4:       return -Q1;
            default: return int'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offer one matrix and hold it until the unit takes the beat. Drop start for a
    // random gap first unless the sender is in its calm stretch; one beat in ten gets
    // a gap, so about a fifth of the cycles idle.
    task automatic send_matrix(input t_mat m);
        if (!calm && $urandom_range(0, 99) < 10) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        i_mat <= m;
        start <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sent++;
    endtask

    // Give up after a generous fixed time; a healthy run needs only a few microseconds.
    initial begin
        #200000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int   i;
        int   pick;
        t_mat m;

        start   <= 1'b0;
        i_mat   <= '0;
        i_rst_n <= 1'b0;
        sent     = 0;
        calm     = 1'b0;

        // Hold reset, then release it on a rising edge.
        repeat (5) @(posedge clk);
        i_rst_n <= 1'b1;

        // Directed matrices: extremes of the entries, each largest component, ties
        // between neighbours, saturation in both directions and proper rotations.
        send_matrix(mat_of(Q1, 0, 0, 0, Q1, 0, 0, 0, Q1));
        send_matrix(mat_of(Q1, 0, 0, 0, -Q1, 0, 0, 0, -Q1));
        send_matrix(mat_of(-Q1, 0, 0, 0, Q1, 0, 0, 0, -Q1));
        send_matrix(mat_of(-Q1, 0, 0, 0, -Q1, 0, 0, 0, Q1));
        send_matrix(mat_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_matrix(mat_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_matrix(mat_of(-32768, -32768, -32768, -32768, -32768, -32768,
                           -32768, -32768, -32768));
        // Tie w against x and y, x against y, y against z, x against z
        send_matrix(mat_of(Q1, 0, 0, 0, Q1, 0, 0, 0, -Q1));
        send_matrix(mat_of(0, 0, 0, 0, 0, 0, 0, 0, -Q1));
        send_matrix(mat_of(-Q1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_matrix(mat_of(0, 0, 0, 0, -Q1, 0, 0, 0, 0));
        // Quarter turn about z and the cyclic axis permutation
        send_matrix(mat_of(0, -Q1, 0, Q1, 0, 0, 0, 0, Q1));
        send_matrix(mat_of(0, 0, Q1, Q1, 0, 0, 0, Q1, 0));
        // Off-diagonals at the limits with the smallest root: drive the clamp both ways
        send_matrix(mat_of(0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0));
        send_matrix(mat_of(0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0));
        send_matrix(mat_of(2, 32767, 32767, 32767, 0, 32767, 32767, 32767, -2));
        send_matrix(mat_of(2, -32768, -32768, -32768, 0, -32768, -32768, -32768, -2));
        send_matrix(mat_of(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
        send_matrix(mat_of(-32768, 32767, -32768, 32767, -32768, 32767,
                           -32768, 32767, -32768));
        // Real rotations, one for each of x, y, z and w leading
        send_matrix(rot_of_quat(0.1, 0.9, 0.3, -0.2, 0));
        send_matrix(rot_of_quat(0.1, -0.3, 0.9, 0.2, 0));
        send_matrix(rot_of_quat(-0.2, 0.3, 0.1, 0.9, 0));
        send_matrix(rot_of_quat(0.8, -0.4, 0.3, 0.3, 0));
        directed = sent;

        // Random part: mostly near-rotations with a little jitter, the rest raw bit
        // patterns and corner-biased entries. Keep the sender calm for a stretch.
        for (i = 0; i < RAND_BEATS; i++) begin
            calm = (i >= 300 && i < 450);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                m = rot_of_quat(unit_rand(), unit_rand(), unit_rand(), unit_rand(),
                                $urandom_range(0, 8));
            end else if (pick < 80) begin
                m = mat_of($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
            end else begin
                m = mat_of(corner_word(), corner_word(), corner_word(), corner_word(),
                           corner_word(), corner_word(), corner_word(), corner_word(),
                           corner_word());
            end
            send_matrix(m);
        end
        start <= 1'b0;

        // Drain the pipeline, then hold on a little longer to catch stray beats.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d matrices (%0d directed), compared %0d quaternion beats",
                 sent, directed, checked);
        $display("Largest component seen: w %0d, x %0d, y %0d, z %0d",
                 hits[0], hits[1], hits[2], hits[3]);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
